// ===== src/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the polyline length and shape check.
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

   localparam int PLC_COORD_BITS = 16;
   localparam int PLC_FRAC_BITS  = 8;
   localparam int PLC_SUM_BITS   = 35;
   localparam int PLC_MIN_POINTS = 4;
   localparam int PLC_PTS_BITS   = 3;
   localparam int PLC_DIGIT_BITS = 2;

   typedef struct packed {
      logic signed [PLC_COORD_BITS-1:0] point_x;
      logic signed [PLC_COORD_BITS-1:0] point_y;
      logic                             last_point;
   } plc_req_type;

   typedef struct packed {
      logic [PLC_SUM_BITS-1:0] total_length;
      logic                    sides_equal;
      logic                    is_closed;
      logic                    is_regular;
      logic                    too_few_points;
   } plc_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MULX,
      ST_MULY,
      ST_ROOT,
      ST_DONE
   } plc_state_type;

   typedef struct packed {
      logic load;
      logic diff;
      logic mul_x;
      logic mul_y;
      logic root_step;
      logic finish;
   } plc_cmd_type;

   typedef struct packed {
      logic first_point;
      logic last;
      logic root_done;
      logic out_blocked;
   } plc_status_type;

endpackage

`default_nettype wire

// ===== src/plc_ctrl.sv =====
// ----------------------------------------------------------------------------
// plc_ctrl
// Sequencer: accept a point, run difference, squares and root (skipped for the
// first point of a polyline), then finish.
`default_nettype none

module plc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire plc_pkg::plc_status_type status,
   output plc_pkg::plc_cmd_type         cmd
);
   import plc_pkg::*;

   plc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.first_point ? ST_DONE : ST_DIFF;
            end
         end
         ST_DIFF: state_in = ST_MULX;
         ST_MULX: state_in = ST_MULY;
         ST_MULY: state_in = ST_ROOT;
         ST_ROOT: begin
            if (status.root_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!(status.last && status.out_blocked)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIFF: cmd.diff      = 1'b1;
         ST_MULX: cmd.mul_x     = 1'b1;
         ST_MULY: cmd.mul_y     = 1'b1;
         ST_ROOT: cmd.root_step = 1'b1;
         ST_DONE: cmd.finish    = !(status.last && status.out_blocked);
         default: cmd           = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/plc_dpath.sv =====
// ----------------------------------------------------------------------------
// plc_dpath
// Point registers, shared squarer, digit-by-digit square root, totals.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_dpath #(
   parameter int FRAC_BITS = plc_pkg::PLC_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire plc_pkg::plc_req_type  req_data,
   input  wire plc_pkg::plc_cmd_type  cmd,
   output plc_pkg::plc_status_type    status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output plc_pkg::plc_rsp_type       rsp_data
);
   import plc_pkg::*;

   localparam int CB      = PLC_COORD_BITS;
   localparam int SQ_BITS = 2 * CB + 1;
   localparam int ROOT_W  = (SQ_BITS + 2 * FRAC_BITS + 1) / 2;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + PLC_DIGIT_BITS;
   localparam int CNT_W   = $clog2(ROOT_W);
   localparam int ACC_W   = ((ROOT_W > PLC_SUM_BITS) ? ROOT_W : PLC_SUM_BITS) + 1;
   localparam logic [PLC_SUM_BITS-1:0] SUM_MAX = '1;

   logic signed [CB-1:0]       cur_x_ff, cur_y_ff, first_x_ff, first_y_ff;
   logic signed [CB-1:0]       prev_x_ff, prev_y_ff;
   logic                       last_ff;
   logic [CB-1:0]              adx_ff, ady_ff;
   logic [SQ_BITS-1:0]         sq_ff, sq_in, first_sq_ff;
   logic [RAD_W-1:0]           rad_ff;
   logic [REM_W-1:0]           rem_ff;
   logic [ROOT_W-1:0]          root_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [PLC_SUM_BITS-1:0]    sum_ff;
   logic                       equal_ff;
   logic [PLC_PTS_BITS-1:0]    pts_ff;
   logic                       rsp_valid_ff;
   plc_rsp_type                rsp_ff;

   logic signed [CB:0]         dx, dy;
   logic [CB-1:0]              adx, ady, mul_a;
   logic [2*CB-1:0]            prod;
   logic [REM_W-1:0]           rem_shift, trial;
   logic [ACC_W-1:0]           acc;
   logic [PLC_SUM_BITS-1:0]    sum_next;
   logic                       equal_next, closed, too_few;
   logic [PLC_PTS_BITS-1:0]    pts_next;

   assign dx  = {cur_x_ff[CB-1], cur_x_ff} - {prev_x_ff[CB-1], prev_x_ff};
   assign dy  = {cur_y_ff[CB-1], cur_y_ff} - {prev_y_ff[CB-1], prev_y_ff};
   assign adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
   assign ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];

   assign mul_a = cmd.mul_y ? ady_ff : adx_ff;
   assign prod  = mul_a * mul_a;
   assign sq_in = cmd.mul_y ? sq_ff + SQ_BITS'(prod) : SQ_BITS'(prod);

   assign rem_shift = {rem_ff[REM_W-PLC_DIGIT_BITS-1:0],
                       rad_ff[RAD_W-1 -: PLC_DIGIT_BITS]};
   assign trial     = {root_ff, 2'b01};

   assign acc      = ACC_W'(sum_ff) + ACC_W'(root_ff);
   assign sum_next = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : acc[PLC_SUM_BITS-1:0];

   assign equal_next = (pts_ff < PLC_PTS_BITS'(2)) ? equal_ff
                                                   : (equal_ff && (sq_ff == first_sq_ff));
   assign closed     = (cur_x_ff == first_x_ff) && (cur_y_ff == first_y_ff);
   assign pts_next   = (pts_ff < PLC_PTS_BITS'(PLC_MIN_POINTS)) ? pts_ff + 1'b1 : pts_ff;
   assign too_few    = pts_next < PLC_PTS_BITS'(PLC_MIN_POINTS);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff <= req_data.point_x;
         cur_y_ff <= req_data.point_y;
         last_ff  <= req_data.last_point;
      end
      if (cmd.diff) begin
         adx_ff <= adx;
         ady_ff <= ady;
      end
      if (cmd.mul_x || cmd.mul_y) begin
         sq_ff <= sq_in;
      end
      if (cmd.mul_y) begin
         rad_ff  <= RAD_W'(sq_in) << (2 * FRAC_BITS);
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end
      if (cmd.root_step) begin
         rad_ff <= rad_ff << PLC_DIGIT_BITS;
         cnt_ff <= cnt_ff + 1'b1;
         if (rem_shift >= trial) begin
            rem_ff  <= rem_shift - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         prev_x_ff <= cur_x_ff;
         prev_y_ff <= cur_y_ff;
         if (pts_ff == '0) begin
            first_x_ff <= cur_x_ff;
            first_y_ff <= cur_y_ff;
         end
         if (pts_ff == PLC_PTS_BITS'(1)) begin
            first_sq_ff <= sq_ff;
         end
         if (last_ff) begin
            if (too_few) begin
               rsp_ff <= '{total_length: '0, sides_equal: 1'b0, is_closed: 1'b0,
                           is_regular: 1'b0, too_few_points: 1'b1};
            end else begin
               rsp_ff <= '{total_length: sum_next, sides_equal: equal_next,
                           is_closed: closed, is_regular: closed && equal_next,
                           too_few_points: 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         equal_ff     <= 1'b1;
         pts_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            if (last_ff) begin
               sum_ff   <= '0;
               equal_ff <= 1'b1;
               pts_ff   <= '0;
            end else begin
               if (pts_ff != '0) begin
                  sum_ff <= sum_next;
               end
               equal_ff <= equal_next;
               pts_ff   <= pts_next;
            end
         end
         if (cmd.finish && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.first_point = (pts_ff == '0);
   assign status.last        = last_ff;
   assign status.root_done   = (cnt_ff == CNT_W'(ROOT_W - 1));
   assign status.out_blocked = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== src/polyline_length_and_shape_check.sv =====
// ----------------------------------------------------------------------------
// polyline_length_and_shape_check
// Sums side lengths of a polyline and reports equal sides, closure, shape.
//
//   channel  dir  handshake            beat
//   req      in   req_valid/ready      point_x, point_y, last_point
//   rsp      out  rsp_valid/ready      total_length, flags (last point only)
//
// The first point of a polyline is accepted and then finished directly; any
// other point runs accept, difference, two squarings on one shared squarer,
// root steps of one two-bit digit each, then finish.
// Reset is synchronous and clears the sequencer, totals and result valid.
// A result waits in its output register; a final point holds in its finish
// cycle while the previous result is still untaken.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_length_and_shape_check #(
   parameter int FRAC_BITS = plc_pkg::PLC_FRAC_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire plc_pkg::plc_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output plc_pkg::plc_rsp_type      rsp_data
);
   import plc_pkg::*;

   plc_cmd_type    cmd;
   plc_status_type status;

   plc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   plc_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready high right after an accepted beat");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish && status.last))
      else $error("result raised without a finishing final point");

   a_too_few_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.too_few_points) |->
         (rsp_data.total_length == '0 && !rsp_data.sides_equal &&
          !rsp_data.is_closed && !rsp_data.is_regular))
      else $error("too-few-points result carries nonzero fields");

endmodule

`default_nettype wire

// ===== test/polyline_length_and_shape_check_tb.sv =====
// ----------------------------------------------------------------------------
// polyline_length_and_shape_check_tb
// Feeds polylines point by point, from short lists to shapes
// that run until the total saturates. A behavioral tracker
// predicts each report. A monitor checks every report field
// by field. Both sides idle at random. One long receiver hold
// fills the block, and drain pauses let it go empty.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_length_and_shape_check_tb;
   import plc_pkg::*;

   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int RANDOM_POINTS   = 1500;
   localparam int SATURATE_POINTS = 1460;
   localparam int RSP_HOLD_CYCLES = 1500;
   localparam int SETTLE_CYCLES   = 80;
   localparam longint unsigned SUM_MAX = (64'd1 << PLC_SUM_BITS) - 1;

   typedef enum {STYLE_FULL, STYLE_TINY, STYLE_CORNER} coord_style_type;

   typedef struct {
      plc_req_type beat;
      bit          gaps_on;
      bit          wait_drain;
      bit          hold_rsp;
   } point_slot_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   plc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   plc_rsp_type rsp_data;

   point_slot_type point_feed[$];
   plc_rsp_type    awaited_reports[$];
   plc_rsp_type    due_report;

   int              first_x, first_y, prev_x, prev_y;
   longint unsigned first_side_sq, length_sum;
   bit              equal_so_far = 1'b1;
   int              points_seen;

   bit   slot_gaps_on, slot_wait_drain, slot_hold_rsp;
   int   points_queued, tx_gap, rsp_stall, rx_phase_left;
   bit   rx_calm;
   logic hold_toggle = 1'b0;
   logic hold_seen   = 1'b0;
   int   error_count, report_count, point_count;
   int   short_count, regular_count, saturated_count, cycle_count;

   polyline_length_and_shape_check i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(15, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic int pick_coord(coord_style_type style);
      case (style)
         STYLE_TINY: return $urandom_range(6) - 3;
         STYLE_CORNER: begin
            case ($urandom_range(4))
               0: return -32768;
               1: return -1;
               2: return 0;
               3: return 1;
               default: return 32767;
            endcase
         end
         default: return $urandom_range(65535) - 32768;
      endcase
   endfunction

   function automatic void add_point(int x, int y, bit last);
      point_slot_type s;
      s.beat.point_x    = x[PLC_COORD_BITS-1:0];
      s.beat.point_y    = y[PLC_COORD_BITS-1:0];
      s.beat.last_point = last;
      s.gaps_on         = slot_gaps_on;
      s.wait_drain      = slot_wait_drain;
      s.hold_rsp        = slot_hold_rsp;
      slot_wait_drain   = 1'b0;
      slot_hold_rsp     = 1'b0;
      point_feed.push_back(s);
      points_queued++;
   endfunction

   // floor of the square root of sq scaled by 4^FRAC_BITS
   function automatic longint unsigned scaled_isqrt(longint unsigned sq);
      longint unsigned rem, root, probe;
      rem   = sq << (2 * PLC_FRAC_BITS);
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic void advance_polyline(plc_req_type p);
      int              px, py;
      longint          dx, dy;
      longint unsigned sq;
      plc_rsp_type     report;
      px = $signed(p.point_x);
      py = $signed(p.point_y);
      point_count++;
      if (points_seen == 0) begin
         first_x = px;
         first_y = py;
      end else begin
         dx = px - prev_x;
         dy = py - prev_y;
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         sq = dx * dx + dy * dy;
         if (points_seen == 1) first_side_sq = sq;
         else if (sq != first_side_sq) equal_so_far = 1'b0;
         length_sum += scaled_isqrt(sq);
         if (length_sum > SUM_MAX) length_sum = SUM_MAX;
      end
      prev_x = px;
      prev_y = py;
      if (points_seen < PLC_MIN_POINTS) points_seen++;
      if (!p.last_point) return;

      report = '0;
      if (points_seen < PLC_MIN_POINTS) begin
         report.too_few_points = 1'b1;
         short_count++;
      end else begin
         report.total_length = length_sum[PLC_SUM_BITS-1:0];
         report.sides_equal  = equal_so_far;
         report.is_closed    = (px == first_x) && (py == first_y);
         report.is_regular   = report.is_closed && equal_so_far;
         if (report.is_regular) regular_count++;
         if (length_sum == SUM_MAX) saturated_count++;
      end
      awaited_reports.push_back(report);
      first_x       = 0;
      first_y       = 0;
      prev_x        = 0;
      prev_y        = 0;
      first_side_sq = 0;
      length_sum    = 0;
      equal_so_far  = 1'b1;
      points_seen   = 0;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_valid && req_ready) advance_polyline(req_data);
         if (!req_valid || req_ready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (point_feed.size() != 0 &&
                         !(point_feed[0].wait_drain && awaited_reports.size() != 0)) begin
               req_data  <= point_feed[0].beat;
               req_valid <= 1'b1;
               if (point_feed[0].hold_rsp) hold_toggle <= ~hold_toggle;
               tx_gap = point_feed[0].gaps_on ? pick_gap() : 0;
               void'(point_feed.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
         rx_phase_left = 0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         rsp_stall = RSP_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_phase_left == 0) begin
            rx_calm = $urandom_range(2) == 0;
            rx_phase_left = $urandom_range(300, 50);
         end
         rx_phase_left--;
         if (!rx_calm && $urandom_range(3) == 0) begin
            rsp_stall = pick_gap();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_reports.size() == 0) begin
            $error("report beat with no report awaited");
            error_count++;
         end else begin
            due_report = awaited_reports.pop_front();
            check_field("total_length", due_report.total_length, rsp_data.total_length);
            check_field("sides_equal", due_report.sides_equal, rsp_data.sides_equal);
            check_field("is_closed", due_report.is_closed, rsp_data.is_closed);
            check_field("is_regular", due_report.is_regular, rsp_data.is_regular);
            check_field("too_few_points", due_report.too_few_points,
                        rsp_data.too_few_points);
            report_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int              n, kind, shape_index, start, laps, bump, last_idx;
      int              ax, ay, ox, oy, cx, cy;
      bit              closed;
      coord_style_type style;

      slot_gaps_on = 1'b1;
      add_point(-32768, 32767, 1'b1);
      add_point(0, 0, 1'b0);
      add_point(32767, -32768, 1'b1);
      add_point(1, 2, 1'b0);
      add_point(-1, -2, 1'b0);
      add_point(1, 2, 1'b1);
      add_point(0, 0, 1'b0);
      add_point(100, 0, 1'b0);
      add_point(100, 100, 1'b0);
      add_point(0, 100, 1'b0);
      add_point(0, 0, 1'b1);
      add_point(-32768, -32768, 1'b0);
      add_point(32767, 32767, 1'b0);
      add_point(-32768, -32768, 1'b0);
      add_point(32767, 32767, 1'b1);
      add_point(0, 0, 1'b0);
      add_point(3, 4, 1'b0);
      add_point(6, 0, 1'b0);
      add_point(0, 0, 1'b1);
      add_point(0, 0, 1'b0);
      add_point(1, 1, 1'b0);
      add_point(2, 2, 1'b0);
      add_point(3, 3, 1'b1);

      start = points_queued;
      shape_index = 0;
      while (points_queued - start < RANDOM_POINTS) begin
         shape_index++;
         if (shape_index % 5 == 4) slot_wait_drain = 1'b1;

         if (shape_index == 10) begin
            // hold the receiver while short polylines pile up
            slot_gaps_on  = 1'b0;
            slot_hold_rsp = 1'b1;
            repeat (24) begin
               for (int i = 0; i < 4; i++)
                  add_point(pick_coord(STYLE_FULL), pick_coord(STYLE_FULL), i == 3);
            end
         end

         if (shape_index == 20) begin
            // drive the total into saturation
            slot_gaps_on = 1'b0;
            for (int i = 0; i < SATURATE_POINTS; i++) begin
               if (i % 2 == 0) add_point(-32768, -32768, i == SATURATE_POINTS - 1);
               else add_point(32767, 32767, i == SATURATE_POINTS - 1);
            end
         end

         slot_gaps_on = $urandom_range(3) != 0;
         kind = $urandom_range(99);
         if (kind < 30) begin
            // rotated square, sometimes with a bumped vertex or left open
            ax = $urandom_range(16000) - 8000;
            ay = $urandom_range(16000) - 8000;
            ox = $urandom_range(32000) - 16000;
            oy = $urandom_range(32000) - 16000;
            laps = $urandom_range(2, 1);
            bump = ($urandom_range(3) == 0) ? $urandom_range(4 * laps - 1, 1) : -1;
            last_idx = ($urandom_range(3) != 0) ? 4 * laps : 4 * laps - 1;
            for (int k = 0; k <= last_idx; k++) begin
               case (k % 4)
                  0: begin cx = ox;           cy = oy;           end
                  1: begin cx = ox + ax;      cy = oy + ay;      end
                  2: begin cx = ox + ax - ay; cy = oy + ay + ax; end
                  default: begin cx = ox - ay; cy = oy + ax;     end
               endcase
               if (k == bump) cx++;
               add_point(cx, cy, k == last_idx);
            end
         end else begin
            if (kind < 55) begin
               style = STYLE_FULL;
               n = $urandom_range(10, 4);
            end else if (kind < 70) begin
               style = STYLE_FULL;
               n = $urandom_range(3, 1);
            end else if (kind < 90) begin
               style = STYLE_TINY;
               n = $urandom_range(9, 4);
            end else begin
               style = STYLE_CORNER;
               n = $urandom_range(8, 2);
            end
            closed = $urandom_range(1);
            cx = pick_coord(style);
            cy = pick_coord(style);
            add_point(cx, cy, n == 1);
            for (int i = 1; i < n; i++) begin
               if (i == n - 1 && closed) add_point(cx, cy, 1'b1);
               else add_point(pick_coord(style), pick_coord(style), i == n - 1);
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (point_feed.size() != 0 || req_valid || awaited_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d reports over %0d points: %0d too short, %0d regular, %0d saturated.",
               report_count, point_count, short_count, regular_count, saturated_count);
      $display("Random gaps on both sides, one long receiver hold and drain pauses applied.");
      if (error_count == 0 && awaited_reports.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/plc_pkg.sv
src/plc_ctrl.sv
src/plc_dpath.sv
src/polyline_length_and_shape_check.sv
test/polyline_length_and_shape_check_tb.sv
